// ===== rtl/mtl_pkg.sv =====
package mtl_pkg;

  // Nesting limit of comment tags and the width of the depth counter.
  localparam int unsigned MAX_COMMENT_DEPTH = 255;
  localparam int unsigned DEPTH_W = $clog2(MAX_COMMENT_DEPTH + 1);

  // One input byte makes at most this many tokens.
  localparam int unsigned MAX_TOK = 4;
  localparam int unsigned CNT_W   = $clog2(MAX_TOK + 1);
  localparam int unsigned SLOT_W  = $clog2(MAX_TOK);

  // Depth of the bundle queue between lexer and serializer.
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

  // Token kinds.
  localparam logic [2:0] TK_TEXT  = 3'd0;
  localparam logic [2:0] TK_OPEN  = 3'd1;
  localparam logic [2:0] TK_NAME  = 3'd2;
  localparam logic [2:0] TK_CLOSE = 3'd3;
  localparam logic [2:0] TK_EOS   = 3'd4;

  // Tag kinds.
  localparam logic [3:0] TAG_ESC    = 4'd0;
  localparam logic [3:0] TAG_SECT   = 4'd1;
  localparam logic [3:0] TAG_END    = 4'd2;
  localparam logic [3:0] TAG_INV    = 4'd3;
  localparam logic [3:0] TAG_AMP    = 4'd4;
  localparam logic [3:0] TAG_CURLY  = 4'd5;
  localparam logic [3:0] TAG_PART   = 4'd6;
  localparam logic [3:0] TAG_EXT    = 4'd7;
  localparam logic [3:0] TAG_BLOCK  = 4'd8;

  // Characters that steer the lexer.
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_DOLLAR = 8'h24;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] tag;
    logic [7:0] value;
    logic       unterm;
  } token_t;

  // All tokens caused by one input byte, in order from slot zero.
  typedef struct packed {
    logic [CNT_W-1:0]           cnt;
    token_t [MAX_TOK-1:0]       tok;
  } bundle_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

// ===== rtl/mtl_in_if.sv =====
interface mtl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

// ===== rtl/mtl_out_if.sv =====
interface mtl_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] token_kind;
  logic [3:0] tag_kind;
  logic [7:0] token_byte;
  logic       unterminated;
  logic       last_of_run;

  modport source (output valid, output token_kind, output tag_kind, output token_byte,
                  output unterminated, output last_of_run, input ready);
  modport sink (input valid, input token_kind, input tag_kind, input token_byte,
                input unterminated, input last_of_run, output ready);
endinterface

// ===== rtl/mtl_front.sv =====
module mtl_front (
  input  logic              clk,
  input  logic              rst_n,
  mtl_in_if.sink            in_ch,
  input  mtl_pkg::q_stat_t  q_stat,
  output logic              push,
  output mtl_pkg::bundle_t  bnd
);
  import mtl_pkg::*;

  // Lexer modes.
  localparam logic [3:0] M_TEXT       = 4'd0;
  localparam logic [3:0] M_OPEN1      = 4'd1;
  localparam logic [3:0] M_SELECT     = 4'd2;
  localparam logic [3:0] M_NAME       = 4'd3;
  localparam logic [3:0] M_NAME_BR    = 4'd4;
  localparam logic [3:0] M_CURLY_EAT  = 4'd5;
  localparam logic [3:0] M_COMMENT    = 4'd6;
  localparam logic [3:0] M_COMMENT_CL = 4'd7;
  localparam logic [3:0] M_COMMENT_OP = 4'd8;

  logic [3:0]         mode_r, mode_nxt;
  logic [3:0]         kind_r, kind_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic               in_fire;

  // Append one token to the bundle.
  function automatic void emit(inout bundle_t b, input logic [2:0] kind,
                               input logic [3:0] tag, input logic [7:0] value,
                               input logic unterm);
    b.tok[b.cnt[SLOT_W-1:0]] = '{kind: kind, tag: tag, value: value, unterm: unterm};
    b.cnt = b.cnt + CNT_W'(1);
  endfunction

  // A byte seen as plain text.
  function automatic void text_byte(input logic [7:0] c, inout logic [3:0] m,
                                    inout bundle_t b);
    if (c == CH_LBRACE) begin
      m = M_OPEN1;
    end else begin
      m = M_TEXT;
      emit(b, TK_TEXT, TAG_ESC, c, 1'b0);
    end
  endfunction

  // A byte seen inside a tag name.
  function automatic void name_byte(input logic [7:0] c, input logic [3:0] k,
                                    inout logic [3:0] m, inout bundle_t b);
    if (c == CH_RBRACE) begin
      m = M_NAME_BR;
    end else begin
      m = M_NAME;
      emit(b, TK_NAME, k, c, 1'b0);
    end
  endfunction

  // A byte seen inside a comment.
  function automatic logic [3:0] comment_byte(input logic [7:0] c);
    if (c == CH_RBRACE) begin
      return M_COMMENT_CL;
    end else if (c == CH_LBRACE) begin
      return M_COMMENT_OP;
    end
    return M_COMMENT;
  endfunction

  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !q_stat.full;
  assign push        = in_fire && (bnd.cnt != '0);

  // Next mode and the tokens that this byte makes.
  always_comb begin
    logic [7:0] c;
    c         = in_ch.data_byte;
    mode_nxt  = mode_r;
    kind_nxt  = kind_r;
    depth_nxt = depth_r;
    bnd       = '0;

    case (mode_r)
      M_OPEN1: begin
        if (c == CH_LBRACE) begin
          mode_nxt = M_SELECT;
        end else begin
          emit(bnd, TK_TEXT, TAG_ESC, CH_LBRACE, 1'b0);
          text_byte(c, mode_nxt, bnd);
        end
      end
      M_SELECT: begin
        if (c == CH_BANG) begin
          depth_nxt = '0;
          mode_nxt  = M_COMMENT;
        end else begin
          mode_nxt = M_NAME;
          case (c)
            CH_HASH:   kind_nxt = TAG_SECT;
            CH_SLASH:  kind_nxt = TAG_END;
            CH_CARET:  kind_nxt = TAG_INV;
            CH_AMP:    kind_nxt = TAG_AMP;
            CH_LBRACE: kind_nxt = TAG_CURLY;
            CH_GT:     kind_nxt = TAG_PART;
            CH_LT:     kind_nxt = TAG_EXT;
            CH_DOLLAR: kind_nxt = TAG_BLOCK;
            default:   kind_nxt = TAG_ESC;
          endcase
          emit(bnd, TK_OPEN, kind_nxt, 8'h00, 1'b0);
          // An unknown selector byte belongs to the name.
          if (kind_nxt == TAG_ESC) begin
            name_byte(c, kind_nxt, mode_nxt, bnd);
          end
        end
      end
      M_NAME: begin
        name_byte(c, kind_r, mode_nxt, bnd);
      end
      M_NAME_BR: begin
        if (c == CH_RBRACE) begin
          emit(bnd, TK_CLOSE, kind_r, 8'h00, 1'b0);
          mode_nxt = (kind_r == TAG_CURLY) ? M_CURLY_EAT : M_TEXT;
        end else begin
          emit(bnd, TK_NAME, kind_r, CH_RBRACE, 1'b0);
          name_byte(c, kind_r, mode_nxt, bnd);
        end
      end
      M_CURLY_EAT: begin
        if (c == CH_RBRACE) begin
          mode_nxt = M_TEXT;
        end else begin
          text_byte(c, mode_nxt, bnd);
        end
      end
      M_COMMENT: begin
        mode_nxt = comment_byte(c);
      end
      M_COMMENT_CL: begin
        if (c == CH_RBRACE) begin
          if (depth_r == '0) begin
            mode_nxt = M_TEXT;
          end else begin
            depth_nxt = depth_r - DEPTH_W'(1);
            mode_nxt  = M_COMMENT;
          end
        end else begin
          mode_nxt = comment_byte(c);
        end
      end
      M_COMMENT_OP: begin
        if (c == CH_LBRACE) begin
          if (depth_r < DEPTH_W'(MAX_COMMENT_DEPTH)) begin
            depth_nxt = depth_r + DEPTH_W'(1);
          end
          mode_nxt = M_COMMENT;
        end else begin
          mode_nxt = comment_byte(c);
        end
      end
      default: begin
        text_byte(c, mode_nxt, bnd);
      end
    endcase

    // The last byte flushes whatever is pending and ends the stream.
    if (in_ch.final_byte) begin
      case (mode_nxt)
        M_OPEN1: begin
          emit(bnd, TK_TEXT, TAG_ESC, CH_LBRACE, 1'b0);
        end
        M_SELECT: begin
          emit(bnd, TK_OPEN, TAG_ESC, 8'h00, 1'b0);
          emit(bnd, TK_CLOSE, TAG_ESC, 8'h00, 1'b1);
        end
        M_NAME: begin
          emit(bnd, TK_CLOSE, kind_nxt, 8'h00, 1'b1);
        end
        M_NAME_BR: begin
          emit(bnd, TK_NAME, kind_nxt, CH_RBRACE, 1'b0);
          emit(bnd, TK_CLOSE, kind_nxt, 8'h00, 1'b1);
        end
        default: begin
        end
      endcase
      emit(bnd, TK_EOS, TAG_ESC, 8'h00, 1'b0);
      mode_nxt  = M_TEXT;
      kind_nxt  = TAG_ESC;
      depth_nxt = '0;
    end
  end

  // Lexer state advances on each input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_TEXT;
      kind_r  <= TAG_ESC;
      depth_r <= '0;
    end else if (in_fire) begin
      mode_r  <= mode_nxt;
      kind_r  <= kind_nxt;
      depth_r <= depth_nxt;
    end
  end

`ifndef SYNTHESIS
  a_final_resets: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.final_byte |=> mode_r == M_TEXT && kind_r == TAG_ESC && depth_r == '0)
    else $error("lexer state not cleared after the last byte");
  a_final_eos: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.final_byte |->
      push && bnd.tok[SLOT_W'(bnd.cnt - CNT_W'(1))].kind == TK_EOS)
    else $error("last byte did not end with an end-of-stream token");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> bnd.cnt <= CNT_W'(MAX_TOK))
    else $error("token bundle overflow");
`endif
endmodule

// ===== rtl/mtl_queue.sv =====
module mtl_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mtl_pkg::bundle_t  push_data,
  input  logic              pop,
  output mtl_pkg::bundle_t  head,
  output mtl_pkg::q_stat_t  q_stat
);
  import mtl_pkg::*;

  localparam int unsigned CW = Q_AW + 1;

  bundle_t         mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;

  assign head         = mem[rd_ptr_r];
  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == CW'(Q_DEPTH));

  // Bundle storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !push)
    else $error("push into a full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from an empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(Q_DEPTH))
    else $error("queue count out of range");
`endif
endmodule

// ===== rtl/mtl_back.sv =====
module mtl_back (
  input  logic              clk,
  input  logic              rst_n,
  input  mtl_pkg::bundle_t  head,
  input  mtl_pkg::q_stat_t  q_stat,
  output logic              pop,
  mtl_out_if.source         out_ch
);
  import mtl_pkg::*;

  logic [SLOT_W-1:0] slot_r;
  logic              valid_r;
  token_t            tok_r;
  logic              last_r;
  logic              load;
  logic              last;

  // Take the next token when the output register is free or draining.
  assign load = !q_stat.empty && (!valid_r || out_ch.ready);
  assign last = (CNT_W'(slot_r) == head.cnt - CNT_W'(1));
  assign pop  = load && last;

  // Control: output valid and slot within the head bundle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      slot_r  <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        slot_r  <= last ? '0 : slot_r + SLOT_W'(1);
      end else if (out_ch.ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      tok_r  <= head.tok[slot_r];
      last_r <= last;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.token_kind   = tok_r.kind;
  assign out_ch.tag_kind     = tok_r.tag;
  assign out_ch.token_byte   = tok_r.value;
  assign out_ch.unterminated = tok_r.unterm;
  assign out_ch.last_of_run  = last_r;

`ifndef SYNTHESIS
  a_slot_in_bundle: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> CNT_W'(slot_r) < head.cnt)
    else $error("slot beyond the bundle");
  a_pop_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> slot_r == '0 && valid_r && last_r)
    else $error("slot not rewound after the bundle's last token");
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !out_ch.ready |-> !load)
    else $error("output register overwritten while stalled");
`endif
endmodule

// ===== rtl/mustache_tag_lexer_unit.sv =====
// Channel   Direction  Payload
// in_ch     sink       data_byte[7:0], final_byte
// out_ch    source     token_kind[2:0], tag_kind[3:0], token_byte[7:0], unterminated,
//                      last_of_run
//
// One byte is taken per cycle while the bundle queue (four entries) has room.
// The lexer turns a byte into up to four tokens in the cycle of its transfer; the serializer
// sends one token a cycle while out_ch is ready, so a byte with n tokens takes n transfers.
// A token goes through the bundle queue and then the output register on its way out.
// Reset is synchronous and active low: it clears the lexer mode, the queue and out_ch.valid.
// A stall on out_ch backs up into the queue; in_ch.ready falls only when the queue is full.
module mustache_tag_lexer_unit (
  input  logic       clk,
  input  logic       rst_n,
  mtl_in_if.sink     in_ch,
  mtl_out_if.source  out_ch
);
  import mtl_pkg::*;

  bundle_t push_data;
  bundle_t head;
  q_stat_t q_stat;
  logic    push;
  logic    pop;

  // Lexer: classifies bytes and builds token bundles.
  mtl_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .push   (push),
    .bnd    (push_data)
  );

  // Bundle queue between lexer and serializer.
  mtl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // Serializer: one token per output transfer.
  mtl_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );
endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  import mtl_pkg::*;

  localparam int CLK_HALF  = 4;
  localparam int RST_CYC   = 10;
  localparam int CYC_LIMIT = 200000;
  localparam int HOLD_CYC  = 120;
  localparam int SETTLE    = 16;
  localparam int ITEM_GOAL = 210;
  localparam int ERR_LINES = 200;

  // Lexer modes of the predictor.
  typedef enum logic [3:0] {
    LX_TEXT, LX_OPEN1, LX_SELECT, LX_NAME, LX_NAME_BR,
    LX_CURLY_EAT, LX_COMMENT, LX_COMMENT_CL, LX_COMMENT_OP
  } lex_mode_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] tag;
    logic [7:0] value;
    logic       unterm;
    logic       last;
  } tok_rec_t;

  // One directed byte; a typed row carries its one token (or none) written out.
  typedef struct packed {
    logic [7:0] data;
    logic       fin;
    logic       typed;
    logic       tok_due;
    tok_rec_t   tok;
  } dir_row_t;

  localparam tok_rec_t NO_TOK = '0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mtl_in_if  in_if ();
  mtl_out_if out_if ();

  mustache_tag_lexer_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // Predictor state.
  lex_mode_t          lx_mode;
  logic [3:0]         lx_tag;
  logic [DEPTH_W-1:0] lx_depth;
  tok_rec_t           step_toks[$];

  // Tokens still owed by the block, oldest first.
  tok_rec_t pending_toks[$];

  int  err_cnt = 0;
  int  cycles = 0;
  int  sent_items = 0;
  int  idle_in_pct = 0;
  int  stall_pct = 0;
  bit  holding = 1'b0;
  event start_hold;

  logic [7:0] tmpl[$];
  dir_row_t   dir_rows[$];

  always #(CLK_HALF) clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYC_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic void push_tok(logic [2:0] k, logic [3:0] t, logic [7:0] v, logic u);
    tok_rec_t rec;
    rec = '{k, t, v, u, 1'b0};
    if (step_toks.size() < MAX_TOK) step_toks.insert(step_toks.size(), rec);
  endfunction

  function automatic void lex_reset();
    lx_mode  = LX_TEXT;
    lx_tag   = TAG_ESC;
    lx_depth = '0;
  endfunction

  function automatic void text_in(logic [7:0] b);
    lx_mode = LX_TEXT;
    if (b == CH_LBRACE) lx_mode = LX_OPEN1;
    else push_tok(TK_TEXT, TAG_ESC, b, 1'b0);
  endfunction

  function automatic void name_in(logic [7:0] b);
    lx_mode = LX_NAME;
    if (b == CH_RBRACE) lx_mode = LX_NAME_BR;
    else push_tok(TK_NAME, lx_tag, b, 1'b0);
  endfunction

  function automatic void comment_in(logic [7:0] b);
    if (b == CH_RBRACE) lx_mode = LX_COMMENT_CL;
    else if (b == CH_LBRACE) lx_mode = LX_COMMENT_OP;
    else lx_mode = LX_COMMENT;
  endfunction

  // The byte after "{{" picks the tag kind; an unknown byte is a name byte.
  function automatic void pick_tag(logic [7:0] b);
    logic [3:0] k;
    bit known;
    k = TAG_ESC;
    known = 1'b1;
    case (b)
      CH_HASH:   k = TAG_SECT;
      CH_SLASH:  k = TAG_END;
      CH_CARET:  k = TAG_INV;
      CH_AMP:    k = TAG_AMP;
      CH_LBRACE: k = TAG_CURLY;
      CH_GT:     k = TAG_PART;
      CH_LT:     k = TAG_EXT;
      CH_DOLLAR: k = TAG_BLOCK;
      CH_BANG: begin
        lx_depth = '0;
        lx_mode = LX_COMMENT;
        return;
      end
      default: known = 1'b0;
    endcase
    lx_tag = k;
    push_tok(TK_OPEN, k, 8'h00, 1'b0);
    if (known) lx_mode = LX_NAME;
    else name_in(b);
  endfunction

  // Works out the tokens that one byte causes into step_toks.
  function automatic void lex_byte(logic [7:0] b, logic fin);
    step_toks.delete();
    case (lx_mode)
      LX_OPEN1: begin
        if (b == CH_LBRACE) lx_mode = LX_SELECT;
        else begin
          push_tok(TK_TEXT, TAG_ESC, CH_LBRACE, 1'b0);
          text_in(b);
        end
      end
      LX_SELECT: pick_tag(b);
      LX_NAME:   name_in(b);
      LX_NAME_BR: begin
        if (b == CH_RBRACE) begin
          push_tok(TK_CLOSE, lx_tag, 8'h00, 1'b0);
          lx_mode = (lx_tag == TAG_CURLY) ? LX_CURLY_EAT : LX_TEXT;
        end else begin
          push_tok(TK_NAME, lx_tag, CH_RBRACE, 1'b0);
          name_in(b);
        end
      end
      LX_CURLY_EAT: begin
        if (b == CH_RBRACE) lx_mode = LX_TEXT;
        else text_in(b);
      end
      LX_COMMENT: comment_in(b);
      LX_COMMENT_CL: begin
        if (b == CH_RBRACE) begin
          if (lx_depth == '0) lx_mode = LX_TEXT;
          else begin
            lx_depth = lx_depth - DEPTH_W'(1);
            lx_mode = LX_COMMENT;
          end
        end else comment_in(b);
      end
      LX_COMMENT_OP: begin
        if (b == CH_LBRACE) begin
          if (lx_depth < DEPTH_W'(MAX_COMMENT_DEPTH)) lx_depth = lx_depth + DEPTH_W'(1);
          lx_mode = LX_COMMENT;
        end else comment_in(b);
      end
      default: text_in(b);
    endcase

    // Last byte: flush whatever is half open, then end of stream.
    if (fin) begin
      case (lx_mode)
        LX_OPEN1: push_tok(TK_TEXT, TAG_ESC, CH_LBRACE, 1'b0);
        LX_SELECT: begin
          lx_tag = TAG_ESC;
          push_tok(TK_OPEN, TAG_ESC, 8'h00, 1'b0);
          push_tok(TK_CLOSE, TAG_ESC, 8'h00, 1'b1);
        end
        LX_NAME: push_tok(TK_CLOSE, lx_tag, 8'h00, 1'b1);
        LX_NAME_BR: begin
          push_tok(TK_NAME, lx_tag, CH_RBRACE, 1'b0);
          push_tok(TK_CLOSE, lx_tag, 8'h00, 1'b1);
        end
        default: ;
      endcase
      push_tok(TK_EOS, TAG_ESC, 8'h00, 1'b0);
      lex_reset();
    end

    if (step_toks.size() != 0) step_toks[step_toks.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_err(input string what, input int got, input int want);
    err_cnt++;
    if (err_cnt <= ERR_LINES)
      $display("ERROR @%0t: %s got %0h want %0h", $time, what, got, want);
  endtask

  // Output side: compare each transfer with the oldest pending token.
  always @(posedge clk) begin
    tok_rec_t got, want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{out_if.token_kind, out_if.tag_kind, out_if.token_byte,
              out_if.unterminated, out_if.last_of_run};
      if (pending_toks.size() == 0) begin
        report_err("token with none pending, kind", int'(got.kind), 0);
      end else begin
        want = pending_toks.pop_front();
        if (got.kind != want.kind)
          report_err("token_kind", int'(got.kind), int'(want.kind));
        if (got.tag != want.tag)
          report_err("tag_kind", int'(got.tag), int'(want.tag));
        if (got.value != want.value)
          report_err("token_byte", int'(got.value), int'(want.value));
        if (got.unterm != want.unterm)
          report_err("unterminated", int'(got.unterm), int'(want.unterm));
        if (got.last != want.last)
          report_err("last_of_run", int'(got.last), int'(want.last));
      end
    end
  end

  // Output ready: random stalls, plus the long hold-off when requested.
  always @(posedge clk) begin
    if (!rst_n) out_if.ready <= 1'b0;
    else out_if.ready <= !holding && ($urandom_range(99) >= stall_pct);
  end

  // Long hold-off, counted here so the sender keeps running meanwhile.
  initial begin
    forever begin
      @(start_hold);
      @(negedge clk);
      holding = 1'b1;
      repeat (HOLD_CYC) @(negedge clk);
      holding = 1'b0;
    end
  end

  // ---------------------------------------------------------------- stimulus

  // Offers one byte with random idle cycles ahead of it; returns at its transfer.
  task automatic put_byte(input logic [7:0] d, input logic f);
    while ($urandom_range(99) < idle_in_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.data_byte  <= d;
    in_if.final_byte <= f;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic send_predicted(input logic [7:0] d, input logic f);
    put_byte(d, f);
    lex_byte(d, f);
    foreach (step_toks[i]) pending_toks.insert(pending_toks.size(), step_toks[i]);
    sent_items++;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_toks.size() != 0);
  endtask

  function automatic void tmpl_add(input logic [7:0] c);
    tmpl.insert(tmpl.size(), c);
  endfunction

  function automatic void add_row(input logic [7:0] d, input logic f, input logic ty,
                                  input logic due, input tok_rec_t t);
    dir_row_t row;
    row = '{d, f, ty, due, t};
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  function automatic logic [7:0] name_char();
    logic [7:0] c;
    c = 8'($urandom_range(8'h7E, 8'h20));
    if (c == CH_RBRACE) c = "n";
    return c;
  endfunction

  function automatic void add_text();
    repeat ($urandom_range(6, 1)) tmpl_add(8'($urandom_range(255)));
  endfunction

  function automatic void add_noise();
    logic [7:0] c;
    repeat ($urandom_range(4, 1)) begin
      case ($urandom_range(3))
        0: c = CH_LBRACE;
        1: c = CH_RBRACE;
        2: c = CH_BANG;
        default: c = 8'($urandom_range(255));
      endcase
      tmpl_add(c);
    end
  endfunction

  // A tag with a random kind and name; now and then a lone '}' or no close.
  function automatic void add_tag();
    logic [7:0] sel;
    case ($urandom_range(9))
      0: sel = CH_HASH;
      1: sel = CH_SLASH;
      2: sel = CH_CARET;
      3: sel = CH_AMP;
      4: sel = CH_LBRACE;
      5: sel = CH_GT;
      6: sel = CH_LT;
      7: sel = CH_DOLLAR;
      default: sel = name_char();
    endcase
    tmpl_add(CH_LBRACE);
    tmpl_add(CH_LBRACE);
    tmpl_add(sel);
    repeat ($urandom_range(5)) begin
      if ($urandom_range(6) == 0) tmpl_add(CH_RBRACE);
      tmpl_add(name_char());
    end
    if ($urandom_range(9) == 0) return;
    tmpl_add(CH_RBRACE);
    tmpl_add(CH_RBRACE);
    if (sel == CH_LBRACE && $urandom_range(1) == 1) tmpl_add(CH_RBRACE);
  endfunction

  // A comment with nested pairs and stray braces inside.
  function automatic void add_comment();
    int lvl;
    lvl = 0;
    tmpl_add(CH_LBRACE);
    tmpl_add(CH_LBRACE);
    tmpl_add(CH_BANG);
    repeat ($urandom_range(6)) begin
      case ($urandom_range(4))
        0: begin
          tmpl_add(CH_LBRACE);
          tmpl_add(CH_LBRACE);
          lvl++;
        end
        1: begin
          if (lvl > 0) begin
            tmpl_add(CH_RBRACE);
            tmpl_add(CH_RBRACE);
            lvl--;
          end else tmpl_add(name_char());
        end
        2: begin
          tmpl_add($urandom_range(1) ? CH_RBRACE : CH_LBRACE);
          tmpl_add(name_char());
        end
        default: tmpl_add(name_char());
      endcase
    end
    repeat (lvl + 1) begin
      tmpl_add(CH_RBRACE);
      tmpl_add(CH_RBRACE);
    end
  endfunction

  // Builds one template of at most room bytes and sends it with the last byte
  // marked; some end early.
  task automatic send_template(input int room);
    int cut;
    tmpl.delete();
    repeat ($urandom_range(5, 1)) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5:             add_text();
        6, 7, 8, 9, 10, 11, 12, 13, 14: add_tag();
        15, 16, 17:                   add_comment();
        default:                      add_noise();
      endcase
    end
    if ($urandom_range(9) == 0) cut = $urandom_range(tmpl.size(), 1);
    else cut = tmpl.size();
    if (cut > room) cut = room;
    while (tmpl.size() > cut) tmpl.delete(tmpl.size() - 1);
    foreach (tmpl[i]) send_predicted(tmpl[i], i == tmpl.size() - 1);
  endtask

  function automatic void load_directed();
    // Text extremes and a lone '{' in text.
    add_row(8'h00, 1'b0, 1'b1, 1'b1, '{TK_TEXT, TAG_ESC, 8'h00, 1'b0, 1'b1});
    add_row(8'hFF, 1'b0, 1'b1, 1'b1, '{TK_TEXT, TAG_ESC, 8'hFF, 1'b0, 1'b1});
    add_row(CH_LBRACE, 1'b0, 1'b1, 1'b0, NO_TOK);
    add_row(8'h78, 1'b0, 1'b0, 1'b0, NO_TOK);
    // Section tag with a lone '}' in its name.
    add_row(CH_LBRACE, 1'b0, 1'b1, 1'b0, NO_TOK);
    add_row(CH_LBRACE, 1'b0, 1'b1, 1'b0, NO_TOK);
    add_row(CH_HASH, 1'b0, 1'b1, 1'b1, '{TK_OPEN, TAG_SECT, 8'h00, 1'b0, 1'b1});
    add_row(CH_RBRACE, 1'b0, 1'b1, 1'b0, NO_TOK);
    add_row(8'h62, 1'b0, 1'b0, 1'b0, NO_TOK);
    add_row(CH_RBRACE, 1'b0, 1'b1, 1'b0, NO_TOK);
    add_row(CH_RBRACE, 1'b0, 1'b1, 1'b1, '{TK_CLOSE, TAG_SECT, 8'h00, 1'b0, 1'b1});
    // Curly tag; the extra '}' after its close is swallowed.
    add_row(CH_LBRACE, 1'b0, 1'b1, 1'b0, NO_TOK);
    add_row(CH_LBRACE, 1'b0, 1'b1, 1'b0, NO_TOK);
    add_row(CH_LBRACE, 1'b0, 1'b1, 1'b1, '{TK_OPEN, TAG_CURLY, 8'h00, 1'b0, 1'b1});
    add_row(8'h7A, 1'b0, 1'b0, 1'b0, NO_TOK);
    add_row(CH_RBRACE, 1'b0, 1'b1, 1'b0, NO_TOK);
    add_row(CH_RBRACE, 1'b0, 1'b1, 1'b1, '{TK_CLOSE, TAG_CURLY, 8'h00, 1'b0, 1'b1});
    add_row(CH_RBRACE, 1'b0, 1'b1, 1'b0, NO_TOK);
    // Comment with a lone brace inside: all silent.
    add_row(CH_LBRACE, 1'b0, 1'b1, 1'b0, NO_TOK);
    add_row(CH_LBRACE, 1'b0, 1'b1, 1'b0, NO_TOK);
    add_row(CH_BANG, 1'b0, 1'b1, 1'b0, NO_TOK);
    add_row(CH_RBRACE, 1'b0, 1'b1, 1'b0, NO_TOK);
    add_row(8'h71, 1'b0, 1'b1, 1'b0, NO_TOK);
    add_row(CH_RBRACE, 1'b0, 1'b1, 1'b0, NO_TOK);
    add_row(CH_RBRACE, 1'b0, 1'b1, 1'b0, NO_TOK);
    // Last byte after bare "{{", in text, and on a pending '{'.
    add_row(CH_LBRACE, 1'b0, 1'b1, 1'b0, NO_TOK);
    add_row(CH_LBRACE, 1'b1, 1'b0, 1'b0, NO_TOK);
    add_row(8'h41, 1'b1, 1'b0, 1'b0, NO_TOK);
    add_row(CH_LBRACE, 1'b1, 1'b0, 1'b0, NO_TOK);
  endfunction

  // Main sequence.
  initial begin
    int in_pct[4];
    int out_pct[4];
    int goal;
    int rand_items;
    in_pct  = '{0, 47, 0, 32};
    out_pct = '{0, 0, 47, 32};

    in_if.valid      = 1'b0;
    in_if.data_byte  = 8'h00;
    in_if.final_byte = 1'b0;
    lex_reset();
    load_directed();

    repeat (RST_CYC) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows.
    foreach (dir_rows[i]) begin
      put_byte(dir_rows[i].data, dir_rows[i].fin);
      lex_byte(dir_rows[i].data, dir_rows[i].fin);
      if (!dir_rows[i].typed) begin
        foreach (step_toks[j]) pending_toks.insert(pending_toks.size(), step_toks[j]);
      end else if (dir_rows[i].tok_due) begin
        pending_toks.insert(pending_toks.size(), dir_rows[i].tok);
      end
    end
    wait_drained();

    // Random templates under each idling mix; the sender drains after each mix.
    rand_items = ITEM_GOAL - dir_rows.size();
    sent_items = 0;
    for (int ph = 0; ph < 4; ph++) begin
      idle_in_pct = in_pct[ph];
      stall_pct   = out_pct[ph];
      goal = (rand_items * (ph + 1)) / 4;
      if (ph == 2) -> start_hold;
      while (sent_items < goal) send_template(goal - sent_items);
      wait_drained();
    end

    repeat (SETTLE) @(posedge clk);
    if (err_cnt == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ===== mustache_tag_lexer_unit.f =====
rtl/mtl_pkg.sv
rtl/mtl_in_if.sv
rtl/mtl_out_if.sv
rtl/mtl_front.sv
rtl/mtl_queue.sv
rtl/mtl_back.sv
rtl/mustache_tag_lexer_unit.sv
verif/tb_top.sv
